### rtl/ejm_pkg.sv
// shared types and constants for the equi-join match engine
`timescale 1ns / 1ps
package ejm_pkg;

	localparam int BuildSlots = 64;
	localparam int MaxResults = 64;
	localparam int SlotW      = $clog2(BuildSlots);
	localparam int CntW       = $clog2(BuildSlots + 1);
	localparam int ResCntW    = $clog2(MaxResults + 1);
	localparam int KeyW       = 64;
	localparam int TagW       = 32;
	localparam int OutSlotW   = 6;
	localparam int QueueDepth = 2;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	// input command codes
	localparam logic [1:0] CMD_BUILD  = 2'd0;
	localparam logic [1:0] CMD_PROBE  = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// join kinds
	localparam logic [1:0] JOIN_INNER = 2'd0;
	localparam logic [1:0] JOIN_LEFT  = 2'd1;
	localparam logic [1:0] JOIN_RIGHT = 2'd2;
	localparam logic [1:0] JOIN_FULL  = 2'd3;

	// result kinds
	localparam logic [1:0] RES_MATCH    = 2'd0;
	localparam logic [1:0] RES_LEFT     = 2'd1;
	localparam logic [1:0] RES_RIGHT    = 2'd2;
	localparam logic [1:0] RES_OVERFLOW = 2'd3;

	typedef enum logic [3:0] {
		OP_BUILD  = 4'b0001,
		OP_PROBE  = 4'b0010,
		OP_FINISH = 4'b0100,
		OP_CLEAR  = 4'b1000
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [KeyW-1:0]   key;
		logic              present;
		logic [TagW-1:0]   tag;
	} op_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [TagW-1:0]    tag;
		logic [SlotW-1:0]   slot;
		logic               last;
	} res_t;

	typedef struct packed {
		logic pop;
	} q_ctl_t;

endpackage

### rtl/ejm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ejm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/ejm_front.sv
// command front end: decode and queue of pending operations
`timescale 1ns / 1ps
module ejm_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              cmd,
	input  logic [63:0]             key,
	input  logic                    key_present,
	input  logic [31:0]             probe_tag,
	output logic                    busy,
	input  ejm_pkg::q_ctl_t         q_ctl_in,
	output logic                    q_not_empty,
	output ejm_pkg::op_t            q_head
);
	import ejm_pkg::*;

	op_t              entry_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] fill_q;
	logic             push;
	op_t              new_op;

	// classify the incoming command
	always_comb begin
		new_op.key     = key;
		new_op.present = key_present;
		new_op.tag     = probe_tag;
		unique case (cmd)
			CMD_BUILD:  new_op.kind = OP_BUILD;
			CMD_PROBE:  new_op.kind = OP_PROBE;
			CMD_FINISH: new_op.kind = OP_FINISH;
			default:    new_op.kind = OP_CLEAR;
		endcase
	end

	assign busy        = (fill_q == QCntW'(QueueDepth));
	assign push        = start && !busy;
	assign q_not_empty = (fill_q != '0);
	assign q_head      = entry_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_op;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (q_ctl_in.pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (push && !q_ctl_in.pop) begin
				fill_q <= fill_q + QCntW'(1);
			end else if (!push && q_ctl_in.pop) begin
				fill_q <= fill_q - QCntW'(1);
			end
		end
	end

endmodule

### rtl/ejm_back.sv
// execution back end: slot store, scan pipeline and result sequencing
`timescale 1ns / 1ps
module ejm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          join_kind,
	input  logic                q_not_empty,
	input  ejm_pkg::op_t        q_head,
	output ejm_pkg::q_ctl_t     q_ctl,
	output logic                result_valid,
	output ejm_pkg::res_t       result
);
	import ejm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_END  = 3'b100
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [CntW-1:0]    count_q;
	logic               probe_seen_q;
	logic [CntW-1:0]    iss_q;
	logic               valid_s1;
	logic [SlotW-1:0]   idx_s1;
	res_t               pend_q;
	logic               pend_v_q;
	logic [ResCntW-1:0] n_q;
	logic               matched_q;
	logic               out_v_q;
	res_t               out_q;

	logic               keep_unmatched;
	logic               right_outer;
	logic               is_probe;
	logic               ram_we;
	logic               ram_re;
	logic [KeyW:0]      ram_rdata;
	logic               hit_we;
	logic [SlotW-1:0]   hit_waddr;
	logic [0:0]         hit_wdata;
	logic [0:0]         hit_rdata;
	logic               found;
	logic               room;
	res_t               new_res;
	logic               emit;
	res_t               emit_res;
	logic               pop;

	assign keep_unmatched = (join_kind == JOIN_LEFT) || (join_kind == JOIN_FULL);
	assign right_outer = (join_kind == JOIN_RIGHT) || (join_kind == JOIN_FULL);
	assign is_probe    = (op_q.kind == OP_PROBE);
	assign pop         = (state_q == ST_IDLE) && q_not_empty;
	assign ram_we      = pop && (q_head.kind == OP_BUILD) && (count_q < CntW'(BuildSlots));
	assign ram_re      = (state_q == ST_SCAN) && (iss_q < count_q);

	assign q_ctl.pop       = pop;

	// key store: present flag over the key bits
	ejm_ram #(
		.Width(KeyW + 1),
		.Depth(BuildSlots)
	) u_keys (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[SlotW-1:0]),
		.wdata({q_head.present, q_head.key}),
		.re   (ram_re),
		.raddr(iss_q[SlotW-1:0]),
		.rdata(ram_rdata)
	);

	// match marks: cleared on slot insert, set by a probe hit under right or full join
	assign hit_we    = ram_we || ((state_q == ST_SCAN) && found && is_probe && right_outer);
	assign hit_waddr = (state_q == ST_SCAN) ? idx_s1 : count_q[SlotW-1:0];
	assign hit_wdata = (state_q == ST_SCAN);

	ejm_ram #(
		.Width(1),
		.Depth(BuildSlots)
	) u_hits (
		.clk  (clk),
		.we   (hit_we),
		.waddr(hit_waddr),
		.wdata(hit_wdata),
		.re   (ram_re),
		.raddr(iss_q[SlotW-1:0]),
		.rdata(hit_rdata)
	);

	// compare stage
	always_comb begin
		if (is_probe) begin
			found = valid_s1 && op_q.present && ram_rdata[KeyW]
				&& (ram_rdata[KeyW-1:0] == op_q.key);
		end else begin
			found = valid_s1 && !hit_rdata[0];
		end
		room         = (n_q < ResCntW'(MaxResults));
		new_res.kind = is_probe ? RES_MATCH : RES_RIGHT;
		new_res.tag  = is_probe ? op_q.tag : '0;
		new_res.slot = idx_s1;
		new_res.last = 1'b0;
	end

	// result selection
	always_comb begin
		emit     = 1'b0;
		emit_res = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && (q_head.kind == OP_BUILD) && !(count_q < CntW'(BuildSlots))) begin
					emit          = 1'b1;
					emit_res.kind = RES_OVERFLOW;
					emit_res.tag  = '0;
					emit_res.slot = '0;
					emit_res.last = 1'b1;
				end
			end
			ST_SCAN: begin
				if (found && room && pend_v_q) begin
					emit          = 1'b1;
					emit_res.last = 1'b0;
				end
			end
			ST_END: begin
				if (pend_v_q) begin
					emit          = 1'b1;
					emit_res.last = 1'b1;
				end else if (is_probe && !matched_q && keep_unmatched) begin
					emit          = 1'b1;
					emit_res.kind = RES_LEFT;
					emit_res.tag  = op_q.tag;
					emit_res.slot = '0;
					emit_res.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// pending result and operation payload
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= q_head;
		end
		if (state_q == ST_SCAN && found && room) begin
			pend_q <= new_res;
		end
		idx_s1 <= iss_q[SlotW-1:0];
		out_q  <= emit_res;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			probe_seen_q <= 1'b0;
			iss_q        <= '0;
			valid_s1     <= 1'b0;
			pend_v_q     <= 1'b0;
			n_q          <= '0;
			matched_q    <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			out_v_q  <= emit;
			valid_s1 <= ram_re;
			unique case (state_q)
				ST_IDLE: begin
					iss_q     <= '0;
					pend_v_q  <= 1'b0;
					n_q       <= '0;
					matched_q <= 1'b0;
					if (pop) begin
						unique case (q_head.kind)
							OP_BUILD: begin
								if (count_q < CntW'(BuildSlots)) begin
									count_q <= count_q + CntW'(1);
								end
							end
							OP_PROBE: begin
								if (count_q != '0) begin
									probe_seen_q <= 1'b1;
									state_q      <= ST_SCAN;
								end
							end
							OP_FINISH: begin
								if (probe_seen_q && right_outer && count_q != '0) begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								count_q      <= '0;
								probe_seen_q <= 1'b0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						iss_q <= iss_q + CntW'(1);
					end
					if (found) begin
						matched_q <= 1'b1;
						if (room) begin
							pend_v_q <= 1'b1;
							n_q      <= n_q + ResCntW'(1);
						end
					end
					if (!ram_re && !valid_s1) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					pend_v_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

### rtl/equi_join_match_engine_unit.sv
// top level of the equi-join match engine
// an overflow result is registered out in the cycle after its command leaves the queue
// a probe on a filled store, and a finish after a probe under right or full join, run the scan and end states
// before the next command is taken; others complete in idle; the final scan result is sent from the end state
// one command per back-end pass; results one per cycle at most, never held off
// reset is asynchronous active low and empties the store and queue; join_kind resets to inner
`timescale 1ns / 1ps
module equi_join_match_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] key,
	input  logic        key_present,
	input  logic [31:0] probe_tag,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	output logic        result_valid,
	output logic [1:0]  result_kind,
	output logic [31:0] tag_out,
	output logic [5:0]  build_slot,
	output logic        last
);
	import ejm_pkg::*;

	logic [1:0] join_kind_q;
	q_ctl_t     q_ctl;
	logic       q_not_empty;
	op_t        q_head;
	res_t       res;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			join_kind_q <= JOIN_INNER;
		end else if (cfg_valid && cfg_ready) begin
			join_kind_q <= cfg_data;
		end
	end

	// command front end
	ejm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.key        (key),
		.key_present(key_present),
		.probe_tag  (probe_tag),
		.busy       (busy),
		.q_ctl_in   (q_ctl),
		.q_not_empty(q_not_empty),
		.q_head     (q_head)
	);

	// execution back end
	ejm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.join_kind   (join_kind_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_ctl       (q_ctl),
		.result_valid(result_valid),
		.result      (res)
	);

	// result ports
	assign result_kind = res.kind;
	assign tag_out     = res.tag;
	assign build_slot  = OutSlotW'(res.slot);
	assign last        = res.last;

`ifndef NO_ASSERTIONS
	a_overflow_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == RES_OVERFLOW |-> last && tag_out == '0)
		else $error("overflow result malformed");
	a_right_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == RES_RIGHT |-> tag_out == '0)
		else $error("right-only result carries a tag");
	a_left_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == RES_LEFT |-> last && build_slot == '0)
		else $error("left-only result malformed");
`endif

endmodule

### tb/sv/tb_equi_join_match_engine_unit.sv
// self-checking testbench for the equi-join match engine
`timescale 1ns / 1ps
module tb_equi_join_match_engine_unit;
	import ejm_pkg::*;

	localparam int IdleLimit = 20000;
	localparam int DrainWait = 120;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] tag;
		logic [5:0]  slot;
		logic        last;
	} join_res_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [63:0] key;
		logic        present;
		logic [31:0] tag;
		logic        typed;
		logic [1:0]  exp_kind;
		logic [5:0]  exp_slot;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [63:0] key;
	logic        key_present;
	logic [31:0] probe_tag;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [31:0] tag_out;
	logic [5:0]  build_slot;
	logic        last;

	// predictor copy of the join store
	logic [63:0] slot_key [BuildSlots];
	logic        slot_ok  [BuildSlots];
	logic        slot_hit [BuildSlots];
	int          slot_cnt;
	logic        seen_probe;
	logic [1:0]  mode;

	join_res_t   pending_res[$];
	int          mismatches;
	int          idle_cycles;
	bit          timed_out;
	bit          calm;
	logic [63:0] key_pool [8];

	equi_join_match_engine_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .key(key),
		.key_present(key_present), .probe_tag(probe_tag), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .result_valid(result_valid),
		.result_kind(result_kind), .tag_out(tag_out), .build_slot(build_slot), .last(last)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// append one predicted result, capped per item
	function automatic void push_res(ref int n, input logic [1:0] k, input logic [31:0] t,
			input int s);
		join_res_t r;
		if (n >= MaxResults) return;
		r.kind = k; r.tag = t; r.slot = s[5:0]; r.last = 1'b0;
		pending_res.insert(pending_res.size(), r);
		n++;
	endfunction

	// work out the results of one accepted command
	function automatic void predict_join(logic [1:0] c, logic [63:0] k, logic p,
			logic [31:0] t);
		int  n;
		bit  hit;
		bit  lo;
		bit  ro;
		n = 0;
		hit = 0;
		lo = (mode == JOIN_LEFT) || (mode == JOIN_FULL);
		ro = (mode == JOIN_RIGHT) || (mode == JOIN_FULL);
		case (c)
			CMD_BUILD: begin
				if (slot_cnt < BuildSlots) begin
					slot_key[slot_cnt] = k;
					slot_ok[slot_cnt] = p;
					slot_hit[slot_cnt] = 1'b0;
					slot_cnt++;
				end else push_res(n, RES_OVERFLOW, '0, 0);
			end
			CMD_PROBE: begin
				if (slot_cnt > 0) begin
					seen_probe = 1'b1;
					if (p) begin
						for (int i = 0; i < slot_cnt; i++) begin
							if (slot_ok[i] && slot_key[i] == k) begin
								hit = 1;
								push_res(n, RES_MATCH, t, i);
								if (ro) slot_hit[i] = 1'b1;
							end
						end
					end
					if (!hit && lo) push_res(n, RES_LEFT, t, 0);
				end
			end
			CMD_FINISH: begin
				if (seen_probe && ro) begin
					for (int i = 0; i < slot_cnt; i++)
						if (!slot_hit[i]) push_res(n, RES_RIGHT, '0, i);
				end
			end
			default: begin
				slot_cnt = 0;
				seen_probe = 1'b0;
				for (int i = 0; i < BuildSlots; i++) slot_hit[i] = 1'b0;
			end
		endcase
		if (n > 0) pending_res[$].last = 1'b1;
	endfunction

	// result checker and idle watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) begin
				if (pending_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result kind=%0d tag=%h slot=%0d last=%0b",
							result_kind, tag_out, build_slot, last);
				end else begin
					join_res_t e;
					e = pending_res.pop_front();
					if (e.kind !== result_kind || e.tag !== tag_out ||
							e.slot !== build_slot || e.last !== last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch exp %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
								e.kind, e.tag, e.slot, e.last,
								result_kind, tag_out, build_slot, last);
					end
				end
			end
			if (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) timed_out = 1;
		end
	end

	// one command transfer, with optional random gap first
	task automatic send_cmd(logic [1:0] c, logic [63:0] k, logic p, logic [31:0] t);
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c; key <= k; key_present <= p; probe_tag <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_join(c, k, p, t);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_res.size() != 0 && !timed_out) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	// join kind write, only while the engine is idle
	task automatic write_mode(logic [1:0] m);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mode = m;
	endtask

	function automatic logic [63:0] rand_key();
		if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
		return key_pool[$urandom_range(0, 7)];
	endfunction

	task automatic run_directed();
		stim_row_t rows [14];
		stim_row_t r;
		join_res_t got;
		// build, probe, finish, clear with extreme keys and tags
		rows[0]  = '{CMD_PROBE, '1, 1'b1, '1, 1'b0, RES_MATCH, 0};
		rows[1]  = '{CMD_FINISH, '0, 1'b0, '0, 1'b0, RES_MATCH, 0};
		rows[2]  = '{CMD_BUILD, '1, 1'b1, '0, 1'b0, RES_MATCH, 0};
		rows[3]  = '{CMD_BUILD, '0, 1'b1, '1, 1'b0, RES_MATCH, 0};
		rows[4]  = '{CMD_BUILD, '1, 1'b0, '0, 1'b0, RES_MATCH, 0};
		rows[5]  = '{CMD_BUILD, '1, 1'b1, '0, 1'b0, RES_MATCH, 0};
		rows[6]  = '{CMD_PROBE, '1, 1'b1, '1, 1'b0, RES_MATCH, 0};
		rows[7]  = '{CMD_PROBE, '0, 1'b1, 32'h5a5a_a5a5, 1'b0, RES_MATCH, 0};
		rows[8]  = '{CMD_PROBE, '1, 1'b0, 32'h1234_5678, 1'b0, RES_MATCH, 0};
		rows[9]  = '{CMD_PROBE, 64'h55, 1'b1, '0, 1'b0, RES_MATCH, 0};
		rows[10] = '{CMD_FINISH, '0, 1'b0, '0, 1'b0, RES_MATCH, 0};
		rows[11] = '{CMD_FINISH, '0, 1'b0, '0, 1'b0, RES_MATCH, 0};
		rows[12] = '{CMD_CLEAR, '1, 1'b1, '1, 1'b0, RES_MATCH, 0};
		rows[13] = '{CMD_PROBE, '1, 1'b1, '1, 1'b0, RES_MATCH, 0};
		foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].key, rows[i].present, rows[i].tag);
		// fill the store, then one build past capacity gives a typed overflow
		for (int i = 0; i < BuildSlots; i++) send_cmd(CMD_BUILD, 64'd7, 1'b1, '0);
		wait_drained();
		r = '{CMD_BUILD, 64'd9, 1'b1, '1, 1'b1, RES_OVERFLOW, 0};
		send_cmd(r.cmd, r.key, r.present, r.tag);
		got = pending_res[0];
		if (got.kind !== r.exp_kind || got.slot !== r.exp_slot || got.tag !== 0 || !got.last) begin
			mismatches++;
			$display("overflow row predicted wrongly kind=%0d", got.kind);
		end
		// full store probe: 64 matches, the last one carries last
		send_cmd(CMD_PROBE, 64'd7, 1'b1, 32'hcafe_0001);
		send_cmd(CMD_FINISH, '0, 1'b0, '0);
	endtask

	initial begin
		int n_build;
		start = 1'b0; cmd = CMD_BUILD; key = '0; key_present = 1'b0; probe_tag = '0;
		cfg_valid = 1'b0; cfg_data = JOIN_INNER;
		slot_cnt = 0; seen_probe = 1'b0; mode = JOIN_INNER;
		mismatches = 0; idle_cycles = 0; timed_out = 0; calm = 0;
		for (int i = 0; i < BuildSlots; i++) slot_hit[i] = 1'b0;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		@(posedge arst_n);
		@(posedge clk);

		// directed part under every join kind
		for (int m = 0; m < 4; m++) begin
			if (m != 0) write_mode(m[1:0]);
			run_directed();
			send_cmd(CMD_CLEAR, '0, 1'b0, '0);
		end

		// random sequences: clear, builds, probes, finishes
		for (int ph = 0; ph < 5; ph++) begin
			write_mode(ph[1:0] ^ 2'($urandom_range(0, 3)));
			if (ph >= 4) calm = 1;
			send_cmd(CMD_CLEAR, '0, 1'b0, '0);
			n_build = $urandom_range(0, 7) == 0 ? 66 : $urandom_range(1, 10);
			for (int i = 0; i < n_build; i++)
				send_cmd(CMD_BUILD, rand_key(), $urandom_range(0, 5) != 0, $urandom);
			for (int i = 0; i < 12; i++) begin
				send_cmd($urandom_range(0, 9) == 0 ? 2'($urandom_range(0, 3)) : CMD_PROBE,
					rand_key(), $urandom_range(0, 5) != 0, $urandom);
			end
			if ($urandom_range(0, 1) == 0) write_mode(2'($urandom_range(0, 3)));
			send_cmd(CMD_FINISH, rand_key(), 1'b1, $urandom);
			send_cmd(CMD_FINISH, '0, 1'b0, '0);
		end

		wait_drained();
		if (!timed_out && mismatches == 0 && pending_res.size() == 0)
			$display("equi_join_match_engine_unit regression: pass");
		else
			$display("equi_join_match_engine_unit regression: fail");
		$finish;
	end

	// watchdog exit
	initial begin
		wait (timed_out);
		$display("equi_join_match_engine_unit regression: fail");
		$finish;
	end

endmodule
